// ===== rtl/heart_rate_lag_estimator_unit_macros.svh =====
// Assertion macros for the heart rate lag estimator.
`ifndef HEART_RATE_LAG_ESTIMATOR_UNIT_MACROS_SVH
`define HEART_RATE_LAG_ESTIMATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define HRLE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define HRLE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define HRLE_ASSERT_IMP(lbl, ante, cons, msg)

`define HRLE_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/hrle_pkg.sv =====
// Types, constants and the rate table of the heart rate lag estimator.
`timescale 1ns / 1ps

package hrle_pkg;

    localparam int SAMPLE_W = 8;
    localparam int LAG_W    = 6;
    localparam int HI_W     = 7;
    localparam int RATE_W   = 11;
    localparam int CONF_W   = 7;
    localparam int SQ_W     = 16;
    localparam int SCORE_W  = 31;

    localparam logic FUNC_PUSH     = 1'b0;
    localparam logic FUNC_ESTIMATE = 1'b1;

    localparam logic CFG_MIN_LAG = 1'b0;
    localparam logic CFG_MAX_LAG = 1'b1;

    localparam logic [LAG_W-1:0]   RESET_MIN_LAG = 6'd7;
    localparam logic [HI_W-1:0]    RESET_MAX_LAG = 7'd37;
    localparam logic [HI_W-1:0]    LAG_CEILING   = 7'd64;
    localparam logic [SCORE_W-1:0] START_SCORE   = 31'h7FFF_FFFF;
    localparam logic [SCORE_W-1:0] CONF_DIVISOR  = 31'd600;
    localparam logic [CONF_W-1:0]  CONF_BASE     = 7'd120;
    localparam logic [CONF_W-1:0]  CONF_MAX      = 7'd100;

    // 60000 ms per minute over 40 ms per sample tick, divided by the lag
    localparam logic [RATE_W-1:0] RATE_TABLE [64] = '{
        11'd0,    11'd1500, 11'd750,  11'd500,  11'd375,  11'd300,  11'd250,  11'd214,
        11'd187,  11'd166,  11'd150,  11'd136,  11'd125,  11'd115,  11'd107,  11'd100,
        11'd93,   11'd88,   11'd83,   11'd78,   11'd75,   11'd71,   11'd68,   11'd65,
        11'd62,   11'd60,   11'd57,   11'd55,   11'd53,   11'd51,   11'd50,   11'd48,
        11'd46,   11'd45,   11'd44,   11'd42,   11'd41,   11'd40,   11'd39,   11'd38,
        11'd37,   11'd36,   11'd35,   11'd34,   11'd34,   11'd33,   11'd32,   11'd31,
        11'd31,   11'd30,   11'd30,   11'd29,   11'd28,   11'd28,   11'd27,   11'd27,
        11'd26,   11'd26,   11'd25,   11'd25,   11'd25,   11'd24,   11'd24,   11'd23
    };

endpackage

// ===== rtl/heart_rate_lag_estimator_unit.sv =====
// Heart rate lag estimator: sample ring and squared difference lag search.
`timescale 1ns / 1ps

// A push request (func 0) stores one sample byte in a DEPTH-entry ring and is taken with no
// result, leaving the unit ready. An estimate request (func 1) scores each lag from min_lag (0 read
// as 1) to max_lag-1 (max_lag capped at 64) as the sum of squared differences over DEPTH-max_lag
// sample pairs, and returns the best lag (the lower lag on a tie), 1500/lag and a confidence of
// 120 - score/600 clamped to 0..100. One subtract-square-accumulate pipeline fed by a two-read
// ring memory handles one sample pair per cycle, and the confidence quotient is then found by
// repeated subtraction before the result is registered. The reset setup scores 30 lags over
// 91 pairs. After reset a clearing pass zeroes the ring before the first request is taken;
// configuration writes are taken at any time.
module heart_rate_lag_estimator_unit
    import hrle_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [HI_W-1:0]     cfg_wr_data,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_func,
    input  logic [SAMPLE_W-1:0] s_sample,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [RATE_W-1:0]   m_rate_bpm,
    output logic [CONF_W-1:0]   m_confidence,
    output logic [LAG_W-1:0]    m_best_lag
);

    localparam int AW = $clog2(DEPTH);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LAG_START,
        ST_ISSUE,
        ST_DRAIN,
        ST_CONF,
        ST_OUT
    } state_t;

    state_t               state_reg;
    logic [SAMPLE_W-1:0]  ring [DEPTH];
    logic [AW-1:0]        clr_ptr_reg;
    logic [AW-1:0]        wp_reg;
    logic [LAG_W-1:0]     min_lag_reg;
    logic [HI_W-1:0]      max_lag_reg;

    logic [LAG_W-1:0]     lag_reg;
    logic [HI_W-1:0]      hi_reg;
    logic [AW-1:0]        window_reg;
    logic [AW-1:0]        cnt_reg;
    logic [AW-1:0]        newer_reg;
    logic [AW-1:0]        older_reg;

    logic [SAMPLE_W-1:0]  rd_new_reg;
    logic [SAMPLE_W-1:0]  rd_old_reg;
    logic                 rd_vld_reg;
    logic [SQ_W-1:0]      sq_reg;
    logic                 sq_vld_reg;
    logic [SCORE_W-1:0]   acc_reg;

    logic [SCORE_W-1:0]   best_score_reg;
    logic [LAG_W-1:0]     best_lag_reg;
    logic [SCORE_W-1:0]   rem_reg;
    logic [CONF_W-1:0]    conf_cnt_reg;

    logic [RATE_W-1:0]    rate_bpm_reg;
    logic [CONF_W-1:0]    confidence_reg;
    logic [LAG_W-1:0]     out_lag_reg;

    logic                 in_accept;
    logic                 push_accept;
    logic                 ring_we;
    logic [AW-1:0]        ring_waddr;
    logic [SAMPLE_W-1:0]  ring_wdata;
    logic [LAG_W-1:0]     lo_eff;
    logic [HI_W-1:0]      hi_eff;
    logic [AW-1:0]        lag_ext;
    logic [AW-1:0]        older_start;
    logic [AW-1:0]        newer_inc;
    logic [AW-1:0]        older_inc;
    logic [AW-1:0]        wp_inc;
    logic signed [SAMPLE_W:0]     diff;
    logic signed [2*SAMPLE_W+1:0] prod;
    logic                 better;
    logic [SCORE_W-1:0]   score_min;
    logic [LAG_W-1:0]     lag_min;
    logic [HI_W-1:0]      lag_succ;

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = (state_reg == ST_OUT);
    assign m_rate_bpm   = rate_bpm_reg;
    assign m_confidence = confidence_reg;
    assign m_best_lag   = out_lag_reg;

    assign in_accept   = s_valid && s_ready;
    assign push_accept = in_accept && (s_func == FUNC_PUSH);

    assign ring_we    = (state_reg == ST_CLEAR) || push_accept;
    assign ring_waddr = (state_reg == ST_CLEAR) ? clr_ptr_reg : wp_reg;
    assign ring_wdata = (state_reg == ST_CLEAR) ? '0 : s_sample;

    assign lo_eff = (min_lag_reg == '0) ? LAG_W'(1) : min_lag_reg;
    assign hi_eff = (max_lag_reg > LAG_CEILING) ? LAG_CEILING : max_lag_reg;

    assign lag_ext     = AW'(lag_reg);
    assign older_start = (wp_reg >= lag_ext) ? (wp_reg - lag_ext)
                                             : (wp_reg + AW'(DEPTH) - lag_ext);
    assign newer_inc   = (newer_reg == AW'(DEPTH - 1)) ? '0 : newer_reg + 1'b1;
    assign older_inc   = (older_reg == AW'(DEPTH - 1)) ? '0 : older_reg + 1'b1;
    assign wp_inc      = (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;

    assign diff = $signed({1'b0, rd_new_reg}) - $signed({1'b0, rd_old_reg});
    assign prod = diff * diff;

    assign better    = (acc_reg < best_score_reg);
    assign score_min = better ? acc_reg : best_score_reg;
    assign lag_min   = better ? lag_reg : best_lag_reg;
    assign lag_succ  = HI_W'(lag_reg) + 1'b1;

    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring[ring_waddr] <= ring_wdata;
        end
        if (state_reg == ST_ISSUE) begin
            rd_new_reg <= ring[newer_reg];
            rd_old_reg <= ring[older_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_ptr_reg <= '0;
            wp_reg      <= '0;
            min_lag_reg <= RESET_MIN_LAG;
            max_lag_reg <= RESET_MAX_LAG;
            rd_vld_reg  <= 1'b0;
            sq_vld_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_MIN_LAG: min_lag_reg <= cfg_wr_data[LAG_W-1:0];
                    CFG_MAX_LAG: max_lag_reg <= cfg_wr_data;
                endcase
            end

            rd_vld_reg <= (state_reg == ST_ISSUE);
            sq_vld_reg <= rd_vld_reg;
            if (rd_vld_reg) begin
                sq_reg <= prod[SQ_W-1:0];
            end
            if (state_reg == ST_LAG_START) begin
                acc_reg <= '0;
            end else if (sq_vld_reg) begin
                acc_reg <= acc_reg + SCORE_W'(sq_reg);
            end

            unique case (state_reg)
                ST_CLEAR: begin
                    clr_ptr_reg <= clr_ptr_reg + 1'b1;
                    if (clr_ptr_reg == AW'(DEPTH - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (push_accept) begin
                        wp_reg <= wp_inc;
                    end else if (in_accept) begin
                        lag_reg        <= lo_eff;
                        hi_reg         <= hi_eff;
                        window_reg     <= AW'(DEPTH) - AW'(hi_eff);
                        best_score_reg <= START_SCORE;
                        best_lag_reg   <= '0;
                        rem_reg        <= START_SCORE;
                        conf_cnt_reg   <= CONF_BASE;
                        if (HI_W'(lo_eff) >= hi_eff) begin
                            state_reg <= ST_CONF;
                        end else begin
                            state_reg <= ST_LAG_START;
                        end
                    end
                end
                ST_LAG_START: begin
                    newer_reg <= wp_reg;
                    older_reg <= older_start;
                    cnt_reg   <= '0;
                    if (window_reg == '0) begin
                        state_reg <= ST_DRAIN;
                    end else begin
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    newer_reg <= newer_inc;
                    older_reg <= older_inc;
                    cnt_reg   <= cnt_reg + 1'b1;
                    if (cnt_reg == window_reg - 1'b1) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!rd_vld_reg && !sq_vld_reg) begin
                        best_score_reg <= score_min;
                        best_lag_reg   <= lag_min;
                        if (lag_succ < hi_reg) begin
                            lag_reg   <= lag_succ[LAG_W-1:0];
                            state_reg <= ST_LAG_START;
                        end else begin
                            rem_reg   <= score_min;
                            state_reg <= ST_CONF;
                        end
                    end
                end
                ST_CONF: begin
                    if ((rem_reg >= CONF_DIVISOR) && (conf_cnt_reg != '0)) begin
                        rem_reg      <= rem_reg - CONF_DIVISOR;
                        conf_cnt_reg <= conf_cnt_reg - 1'b1;
                    end else begin
                        confidence_reg <= (conf_cnt_reg > CONF_MAX) ? CONF_MAX : conf_cnt_reg;
                        rate_bpm_reg   <= RATE_TABLE[best_lag_reg];
                        out_lag_reg    <= best_lag_reg;
                        state_reg      <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
            endcase
        end
    end

`include "heart_rate_lag_estimator_unit_macros.svh"

    `HRLE_ASSERT_IMP(a_result_blocks_input, m_valid, !s_ready, "request taken while result waits")
    `HRLE_ASSERT_NXT(a_estimate_busy, in_accept && (s_func == FUNC_ESTIMATE), !s_ready, "estimate did not start")
    `HRLE_ASSERT_NXT(a_push_single_cycle, push_accept, s_ready, "push did not finish in one cycle")
    `HRLE_ASSERT_IMP(a_rate_matches_lag, m_valid, (m_best_lag == '0) == (m_rate_bpm == '0), "rate and lag disagree")
    `HRLE_ASSERT_IMP(a_confidence_range, m_valid, m_confidence <= CONF_MAX, "confidence above ceiling")

endmodule

// ===== tb/sv/hrle_lag_checker.sv =====
// Lag estimator checker: mirrors ring and lag registers, predicts and compares estimates.
`timescale 1ns / 1ps
module hrle_lag_checker
    import hrle_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [HI_W-1:0]     cfg_wr_data,

    input  logic                s_valid,
    input  logic                s_ready,
    input  logic                s_func,
    input  logic [SAMPLE_W-1:0] s_sample,

    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [RATE_W-1:0]   m_rate_bpm,
    input  logic [CONF_W-1:0]   m_confidence,
    input  logic [LAG_W-1:0]    m_best_lag,

    output int                  mismatches,
    output int                  pending,
    output int                  results_seen
);

    localparam int MS_PER_MINUTE = 60000;
    localparam int MS_PER_TICK   = 40;
    localparam int PTR_W         = $clog2(DEPTH);

    typedef struct packed {
        logic [RATE_W-1:0] rate_bpm;
        logic [CONF_W-1:0] confidence;
        logic [LAG_W-1:0]  best_lag;
    } estimate_t;

    logic [SAMPLE_W-1:0] ring [DEPTH];
    logic [PTR_W-1:0]    wr_ptr;
    logic [LAG_W-1:0]    min_lag;
    logic [HI_W-1:0]     max_lag;
    estimate_t           expected_estimates [$];

    function automatic int squared_distance(input int lag, input int span);
        int newer;
        int older;
        int diff;
        int sum;
        int i;
        newer = int'(wr_ptr);
        older = (int'(wr_ptr) + DEPTH - lag) % DEPTH;
        sum   = 0;
        for (i = 0; i < span; i++) begin
            diff  = int'(ring[newer]) - int'(ring[older]);
            sum  += diff * diff;
            newer = (newer + 1) % DEPTH;
            older = (older + 1) % DEPTH;
        end
        return sum;
    endfunction

    function automatic estimate_t predict_estimate();
        int        lo;
        int        hi;
        int        span;
        int        lag;
        int        score;
        int        best_score;
        int        best;
        int        quot;
        int        conf;
        int        rate;
        estimate_t est;
        lo         = (min_lag == 0) ? 1 : int'(min_lag);
        hi         = (max_lag > LAG_CEILING) ? int'(LAG_CEILING) : int'(max_lag);
        span       = (hi < DEPTH) ? DEPTH - hi : 0;
        best_score = int'(START_SCORE);
        best       = 0;
        for (lag = lo; lag < hi; lag++) begin
            score = squared_distance(lag, span);
            if (score < best_score) begin
                best_score = score;
                best       = lag;
            end
        end
        quot = best_score / int'(CONF_DIVISOR);
        conf = (quot >= int'(CONF_BASE)) ? 0 : int'(CONF_BASE) - quot;
        if (conf > int'(CONF_MAX)) begin
            conf = int'(CONF_MAX);
        end
        rate = (best == 0) ? 0 : MS_PER_MINUTE / (best * MS_PER_TICK);
        est.rate_bpm   = RATE_W'(rate);
        est.confidence = CONF_W'(conf);
        est.best_lag   = LAG_W'(best);
        return est;
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : watch
        estimate_t want;
        if (!aresetn) begin
            foreach (ring[i]) begin
                ring[i] = '0;
            end
            wr_ptr  = '0;
            min_lag = RESET_MIN_LAG;
            max_lag = RESET_MAX_LAG;
            expected_estimates.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_MIN_LAG) begin
                    min_lag = cfg_wr_data[LAG_W-1:0];
                end else begin
                    max_lag = cfg_wr_data;
                end
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_estimates.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with none expected: rate %0d conf %0d lag %0d",
                             $time, m_rate_bpm, m_confidence, m_best_lag);
                end else begin
                    want = expected_estimates.pop_front();
                    compare_field("rate_bpm", int'(want.rate_bpm), int'(m_rate_bpm));
                    compare_field("confidence", int'(want.confidence), int'(m_confidence));
                    compare_field("best_lag", int'(want.best_lag), int'(m_best_lag));
                end
            end
            if (s_valid && s_ready) begin
                if (s_func == FUNC_PUSH) begin
                    ring[wr_ptr] = s_sample;
                    wr_ptr       = wr_ptr + 1'b1;
                end else begin
                    expected_estimates.push_back(predict_estimate());
                end
            end
        end
        pending = expected_estimates.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Lag estimator testbench top: clock, reset, request stimulus, lag settings and verdict.
`timescale 1ns / 1ps
module tb_top;
    import hrle_pkg::*;

    localparam int DEPTH         = 128;
    localparam int CYCLE_LIMIT   = 20_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 200;
    localparam int SHAPE_MAX     = 64;
    localparam logic [SAMPLE_W-1:0] CORNER_SAMPLES [10] = '{
        8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'hFF, 8'h00, 8'h7F, 8'hFE
    };

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic                cfg_index;
    logic [HI_W-1:0]     cfg_wr_data;
    logic                s_valid;
    logic                s_ready;
    logic                s_func;
    logic [SAMPLE_W-1:0] s_sample;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [RATE_W-1:0]   m_rate_bpm;
    logic [CONF_W-1:0]   m_confidence;
    logic [LAG_W-1:0]    m_best_lag;

    int mismatches;
    int pending;
    int results_seen;
    int send_idle_pct;
    int recv_idle_pct;
    int cycle_count;
    int requests_sent;
    int estimates_sent;
    int lag_settings;

    logic [SAMPLE_W-1:0] shape [SHAPE_MAX];
    int                  shape_len;
    int                  shape_pos;

    heart_rate_lag_estimator_unit #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_sample    (s_sample),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_rate_bpm  (m_rate_bpm),
        .m_confidence(m_confidence),
        .m_best_lag  (m_best_lag)
    );

    hrle_lag_checker #(
        .DEPTH(DEPTH)
    ) lag_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_sample    (s_sample),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_rate_bpm  (m_rate_bpm),
        .m_confidence(m_confidence),
        .m_best_lag  (m_best_lag),
        .mismatches  (mismatches),
        .pending     (pending),
        .results_seen(results_seen)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("heart_rate_lag_estimator_unit: mismatch");
            $finish;
        end
    end

    task automatic send_request(input logic func, input logic [SAMPLE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_func   <= func;
        s_sample <= value;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        requests_sent++;
        @(negedge aclk);
    endtask

    task automatic request_estimate();
        send_request(FUNC_ESTIMATE, SAMPLE_W'($urandom_range(255)));
        estimates_sent++;
    endtask

    task automatic drain_results(input int settle);
        s_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge aclk);
        end
        repeat (settle) @(negedge aclk);
    endtask

    task automatic apply_lags(input logic [HI_W-1:0] min_data, input logic [HI_W-1:0] max_data);
        drain_results(SETTLE_CYCLES);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_MIN_LAG;
        cfg_wr_data <= min_data;
        @(negedge aclk);
        cfg_index   <= CFG_MAX_LAG;
        cfg_wr_data <= max_data;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        lag_settings++;
    endtask

    task automatic random_lags();
        int hi;
        int lo;
        if ($urandom_range(3) != 0) begin
            hi = $urandom_range(2, 64);
            lo = $urandom_range(1, hi - 1);
            apply_lags(HI_W'(lo) | ($urandom_range(1) ? 7'h40 : 7'h00), HI_W'(hi));
        end else begin
            apply_lags(HI_W'($urandom_range(127)), HI_W'($urandom_range(127)));
        end
    endtask

    task automatic new_shape();
        shape_len = $urandom_range(1, SHAPE_MAX - 1);
        foreach (shape[k]) begin
            shape[k] = SAMPLE_W'($urandom_range(255));
        end
        shape_pos = 0;
    endtask

    task automatic push_shape(input int count);
        logic [SAMPLE_W-1:0] value;
        repeat (count) begin
            value = shape[shape_pos];
            if ($urandom_range(3) == 0) begin
                value ^= SAMPLE_W'($urandom_range(3));
            end
            send_request(FUNC_PUSH, value);
            shape_pos = (shape_pos + 1) % shape_len;
        end
    endtask

    initial begin
        int phase;
        int mode;
        int start_requests;
        int start_estimates;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_func        = FUNC_PUSH;
        s_sample      = '0;
        cfg_wr_en     = 1'b0;
        cfg_index     = CFG_MIN_LAG;
        cfg_wr_data   = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        new_shape();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        request_estimate();
        foreach (CORNER_SAMPLES[k]) begin
            send_request(FUNC_PUSH, CORNER_SAMPLES[k]);
        end
        request_estimate();
        request_estimate();
        apply_lags(7'd0, 7'd127);
        request_estimate();
        apply_lags(7'd63, 7'd64);
        request_estimate();
        apply_lags(7'd20, 7'd20);
        request_estimate();
        apply_lags(7'd20, 7'd0);
        request_estimate();
        apply_lags(7'd1, 7'd2);
        request_estimate();
        apply_lags(7'h45, 7'd65);
        request_estimate();

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 9;
                    recv_idle_pct = 66;
                end
                1: begin
                    send_idle_pct = 66;
                    recv_idle_pct = 9;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            random_lags();
            new_shape();
            start_requests  = requests_sent;
            start_estimates = estimates_sent;
            while (requests_sent - start_requests < 64 ||
                   estimates_sent - start_estimates < 6) begin
                if ($urandom_range(5) == 0) begin
                    random_lags();
                end
                mode = $urandom_range(99);
                if (mode < 70 && $urandom_range(3) == 0) begin
                    new_shape();
                end
                if (mode < 60) begin
                    push_shape($urandom_range(2, 12));
                    request_estimate();
                end else if (mode < 70) begin
                    push_shape($urandom_range(24, 48));
                    request_estimate();
                end else if (mode < 80) begin
                    repeat ($urandom_range(1, 6)) begin
                        send_request(FUNC_PUSH, SAMPLE_W'($urandom_range(255)));
                    end
                    request_estimate();
                end else if (mode < 88) begin
                    request_estimate();
                end else if (mode < 95) begin
                    push_shape($urandom_range(1, 10));
                end else begin
                    drain_results(1);
                    request_estimate();
                end
            end
        end

        drain_results(DRAIN_CYCLES);
        $display("run covered %0d requests, %0d of them estimates, under %0d lag settings",
                 requests_sent, estimates_sent, lag_settings);
        $display("%0d estimate results checked field by field", results_seen);
        if (mismatches == 0 && pending == 0) begin
            $display("heart_rate_lag_estimator_unit: match");
        end else begin
            $display("heart_rate_lag_estimator_unit: mismatch");
        end
        $finish;
    end

endmodule
